// ----- sv/tgss_pkg.sv -----
`default_nettype none
package tgss_pkg;

    localparam int POS_WIDTH = 16;
    localparam int FIELD_W = 16;
    localparam int CNT_BITS = POS_WIDTH + 1;
    localparam int SHIFT_W = $clog2(CNT_BITS);
    localparam int DIV_CNT_W = $clog2(CNT_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_GCD,
        S_DIVX,
        S_DIVY,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic gcd_step;
        logic gcd_load;
        logic div_step;
        logic div_next_y;
        logic div_end;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic moving;
        logic gcd_done;
        logic null_move;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- sv/tgss_cmd_if.sv -----
`default_nettype none
interface tgss_cmd_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic signed [tgss_pkg::FIELD_W-1:0] target_x;
    logic signed [tgss_pkg::FIELD_W-1:0] target_y;

    modport source (output valid, output action, output target_x, output target_y,
                    input ready);
    modport sink (input valid, input action, input target_x, input target_y,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/tgss_res_if.sv -----
`default_nettype none
interface tgss_res_if;
    logic                                valid;
    logic                                ready;
    logic                                step_x;
    logic                                step_y;
    logic                                dir_x;
    logic                                dir_y;
    logic                                busy_res;
    logic signed [tgss_pkg::FIELD_W-1:0] now_x;
    logic signed [tgss_pkg::FIELD_W-1:0] now_y;

    modport source (output valid, output step_x, output step_y, output dir_x,
                    output dir_y, output busy_res, output now_x, output now_y,
                    input ready);
    modport sink (input valid, input step_x, input step_y, input dir_x,
                  input dir_y, input busy_res, input now_x, input now_y,
                  output ready);
endinterface
`default_nettype wire

// ----- sv/two_axis_gcd_step_sequencer.sv -----
// two-axis stepper sequencer along a gcd-reduced staircase
// i_cmd: input transfers with action (0 = move target, 1 = step tick) and
//   signed 16-bit targets; o_res: one result transfer per input transfer
//   with step pulses, direction bits, busy flag and current positions
// a move target is taken only while idle; while busy it is answered with
//   the current state and no step
// sequence: a tick or an ignored command goes from capture straight to the
//   emit state; a move command runs a setup state, the binary gcd loop
//   (one bit reduction per cycle) and two divisions on the one shared
//   restoring divider before it emits; a null move skips the divisions
// throughput: one item at a time, a new item is taken in the cycle after
//   the previous result is loaded into the output register
// a stalled receiver holds the result in the output register; the next
//   item is still taken and worked on, and its result waits until the
//   register drains
// reset: positions zero, both directions increasing, no move in progress,
//   output register empty
`default_nettype none
module two_axis_gcd_step_sequencer (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tgss_cmd_if.sink   i_cmd,
    tgss_res_if.source o_res
);

    tgss_pkg::t_dp_cmd dp_cmd;
    tgss_pkg::t_dp_sts dp_sts;

    tgss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_action (i_cmd.action),
        .o_in_ready  (i_cmd.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    tgss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_action    (i_cmd.action),
        .i_target_x  (i_cmd.target_x),
        .i_target_y  (i_cmd.target_y),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_step_x    (o_res.step_x),
        .o_step_y    (o_res.step_y),
        .o_dir_x     (o_res.dir_x),
        .o_dir_y     (o_res.dir_y),
        .o_busy_res  (o_res.busy_res),
        .o_now_x     (o_res.now_x),
        .o_now_y     (o_res.now_y)
    );

endmodule
`default_nettype wire

// ----- sv/tgss_ctrl.sv -----
`default_nettype none
module tgss_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_action,
    output logic                   o_in_ready,
    input  wire tgss_pkg::t_dp_sts i_sts,
    output tgss_pkg::t_dp_cmd      o_cmd
);

    tgss_pkg::t_state r_state;
    tgss_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tgss_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            tgss_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (!i_in_action && !i_sts.moving) begin
                        n_state = tgss_pkg::S_PREP;
                    end else begin
                        n_state = tgss_pkg::S_EMIT;
                    end
                end
            end
            tgss_pkg::S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = tgss_pkg::S_GCD;
            end
            tgss_pkg::S_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.gcd_load = 1'b1;
                    if (i_sts.null_move) begin
                        n_state = tgss_pkg::S_EMIT;
                    end else begin
                        n_state = tgss_pkg::S_DIVX;
                    end
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            tgss_pkg::S_DIVX: begin
                if (i_sts.div_done) begin
                    o_cmd.div_next_y = 1'b1;
                    n_state          = tgss_pkg::S_DIVY;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            tgss_pkg::S_DIVY: begin
                if (i_sts.div_done) begin
                    o_cmd.div_end = 1'b1;
                    n_state       = tgss_pkg::S_EMIT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            tgss_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = tgss_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tgss_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/tgss_dp.sv -----
`default_nettype none
module tgss_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire tgss_pkg::t_dp_cmd                   i_cmd,
    output tgss_pkg::t_dp_sts                        o_sts,
    input  wire logic                                i_action,
    input  wire logic signed [tgss_pkg::FIELD_W-1:0] i_target_x,
    input  wire logic signed [tgss_pkg::FIELD_W-1:0] i_target_y,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic                                     o_step_x,
    output logic                                     o_step_y,
    output logic                                     o_dir_x,
    output logic                                     o_dir_y,
    output logic                                     o_busy_res,
    output logic signed [tgss_pkg::FIELD_W-1:0]      o_now_x,
    output logic signed [tgss_pkg::FIELD_W-1:0]      o_now_y
);

    localparam int PW = tgss_pkg::POS_WIDTH;
    localparam int CW = tgss_pkg::CNT_BITS;
    localparam int FW = tgss_pkg::FIELD_W;

    // captured item
    logic                 r_act;
    logic signed [FW-1:0] r_tx;
    logic signed [FW-1:0] r_ty;

    // move setup
    logic [CW-1:0] r_cx;
    logic [CW-1:0] r_cy;
    logic          r_dxp;
    logic          r_dyn;
    logic          r_dyp;

    // gcd unit
    logic [CW-1:0]                    r_ga;
    logic [CW-1:0]                    r_gb;
    logic [tgss_pkg::SHIFT_W-1:0]     r_gk;
    logic [CW-1:0]                    r_g;

    // shared divider
    logic [CW-1:0]                    r_rem;
    logic [CW-1:0]                    r_quo;
    logic [tgss_pkg::DIV_CNT_W-1:0]   r_dcnt;
    logic [CW-1:0]                    r_mx_new;
    logic [CW-1:0]                    r_my_new;

    // sequencer state
    logic [PW-1:0] r_pos_x;
    logic [PW-1:0] r_pos_y;
    logic          r_dir_x;
    logic          r_dir_y;
    logic [CW-1:0] r_rounds;
    logic [CW-1:0] r_mult_x;
    logic [CW-1:0] r_mult_y;
    logic [CW-1:0] r_burst;
    logic          r_phase_x;
    logic          r_moving;

    logic [PW-1:0] n_pos_x;
    logic [PW-1:0] n_pos_y;
    logic          n_dir_x;
    logic          n_dir_y;
    logic [CW-1:0] n_rounds;
    logic [CW-1:0] n_mult_x;
    logic [CW-1:0] n_mult_y;
    logic [CW-1:0] n_burst;
    logic          n_phase_x;
    logic          n_moving;
    logic          n_sx;
    logic          n_sy;

    // output register
    logic                 r_out_valid;
    logic                 r_o_step_x;
    logic                 r_o_step_y;
    logic                 r_o_dir_x;
    logic                 r_o_dir_y;
    logic                 r_o_busy;
    logic signed [FW-1:0] r_o_now_x;
    logic signed [FW-1:0] r_o_now_y;

    // axis counts
    logic [PW-1:0]      tgt_x;
    logic [PW-1:0]      tgt_y;
    logic signed [PW:0] d_x;
    logic signed [PW:0] d_y;
    logic [CW-1:0]      abs_x;
    logic [CW-1:0]      abs_y;

    always_comb begin
        tgt_x = PW'(r_tx);
        tgt_y = PW'(r_ty);
        d_x   = $signed({tgt_x[PW-1], tgt_x}) - $signed({r_pos_x[PW-1], r_pos_x});
        d_y   = $signed({tgt_y[PW-1], tgt_y}) - $signed({r_pos_y[PW-1], r_pos_y});
        abs_x = d_x[PW] ? CW'(-d_x) : CW'(d_x);
        abs_y = d_y[PW] ? CW'(-d_y) : CW'(d_y);
    end

    // binary gcd step
    logic          gcd_done;
    logic [CW-1:0] gcd_val;
    logic [CW-1:0] n_ga;
    logic [CW-1:0] n_gb;
    logic [tgss_pkg::SHIFT_W-1:0] n_gk;

    always_comb begin
        gcd_done = (r_ga == '0) || (r_gb == '0) || (r_ga == r_gb);
        gcd_val  = ((r_ga == '0) ? r_gb : r_ga) << r_gk;
        n_ga     = r_ga;
        n_gb     = r_gb;
        n_gk     = r_gk;
        if (!r_ga[0] && !r_gb[0]) begin
            n_ga = r_ga >> 1;
            n_gb = r_gb >> 1;
            n_gk = r_gk + 1'b1;
        end else if (!r_ga[0]) begin
            n_ga = r_ga >> 1;
        end else if (!r_gb[0]) begin
            n_gb = r_gb >> 1;
        end else if (r_ga > r_gb) begin
            n_ga = (r_ga - r_gb) >> 1;
        end else begin
            n_gb = (r_gb - r_ga) >> 1;
        end
    end

    // restoring division step
    logic [CW:0]   div_trial;
    logic [CW:0]   div_diff;
    logic          div_ge;
    logic [CW-1:0] n_rem;
    logic [CW-1:0] n_quo;

    always_comb begin
        div_trial = {r_rem, r_quo[CW-1]};
        div_diff  = div_trial - {1'b0, r_g};
        div_ge    = div_trial >= {1'b0, r_g};
        n_rem     = div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
        n_quo     = {r_quo[CW-2:0], div_ge};
    end

    // result of one item
    logic is_cmd;
    logic is_tick;
    logic do_settle;

    always_comb begin
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_dir_x   = r_dir_x;
        n_dir_y   = r_dir_y;
        n_rounds  = r_rounds;
        n_mult_x  = r_mult_x;
        n_mult_y  = r_mult_y;
        n_burst   = r_burst;
        n_phase_x = r_phase_x;
        n_moving  = r_moving;
        n_sx      = 1'b0;
        n_sy      = 1'b0;
        do_settle = 1'b0;
        is_cmd    = !r_act && !r_moving;
        is_tick   = r_act && r_moving && (r_burst != '0);
        if (is_cmd) begin
            if (r_cx == '0) begin
                n_dir_y = !r_dyn;
            end else begin
                n_dir_x = r_dxp;
                if (r_cy != '0) begin
                    n_dir_y = r_dyp;
                end
            end
            if ((r_cx != '0) || (r_cy != '0)) begin
                n_rounds  = r_g;
                n_mult_x  = r_mx_new;
                n_mult_y  = r_my_new;
                n_phase_x = 1'b0;
                n_burst   = r_my_new;
                n_moving  = 1'b1;
                do_settle = 1'b1;
            end
        end else if (is_tick) begin
            if (r_phase_x) begin
                n_sx    = 1'b1;
                n_pos_x = r_dir_x ? r_pos_x + 1'b1 : r_pos_x - 1'b1;
            end else begin
                n_sy    = 1'b1;
                n_pos_y = r_dir_y ? r_pos_y + 1'b1 : r_pos_y - 1'b1;
            end
            n_burst   = r_burst - 1'b1;
            do_settle = 1'b1;
        end
        // skip empty or finished bursts
        if (do_settle) begin
            for (int k = 0; k < 4; k++) begin
                if (n_moving && (n_burst == '0)) begin
                    if (!n_phase_x) begin
                        n_phase_x = 1'b1;
                        n_burst   = n_mult_x;
                    end else begin
                        if (n_rounds != '0) begin
                            n_rounds = n_rounds - 1'b1;
                        end
                        if (n_rounds == '0) begin
                            n_moving = 1'b0;
                        end else begin
                            n_phase_x = 1'b0;
                            n_burst   = n_mult_y;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_dir_x     <= 1'b1;
            r_dir_y     <= 1'b1;
            r_rounds    <= '0;
            r_mult_x    <= '0;
            r_mult_y    <= '0;
            r_burst     <= '0;
            r_phase_x   <= 1'b0;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_pos_x     <= n_pos_x;
                r_pos_y     <= n_pos_y;
                r_dir_x     <= n_dir_x;
                r_dir_y     <= n_dir_y;
                r_rounds    <= n_rounds;
                r_mult_x    <= n_mult_x;
                r_mult_y    <= n_mult_y;
                r_burst     <= n_burst;
                r_phase_x   <= n_phase_x;
                r_moving    <= n_moving;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act <= i_action;
            r_tx  <= i_target_x;
            r_ty  <= i_target_y;
        end
        if (i_cmd.prep) begin
            r_cx  <= abs_x;
            r_cy  <= abs_y;
            r_dxp <= !d_x[PW] && (d_x != '0);
            r_dyn <= d_y[PW];
            r_dyp <= !d_y[PW] && (d_y != '0);
            r_ga  <= abs_x;
            r_gb  <= abs_y;
            r_gk  <= '0;
        end
        if (i_cmd.gcd_step) begin
            r_ga <= n_ga;
            r_gb <= n_gb;
            r_gk <= n_gk;
        end
        if (i_cmd.gcd_load) begin
            r_g    <= gcd_val;
            r_rem  <= '0;
            r_quo  <= r_cx;
            r_dcnt <= tgss_pkg::DIV_CNT_W'(CW);
        end
        if (i_cmd.div_step) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.div_next_y) begin
            r_mx_new <= r_quo;
            r_rem    <= '0;
            r_quo    <= r_cy;
            r_dcnt   <= tgss_pkg::DIV_CNT_W'(CW);
        end
        if (i_cmd.div_end) begin
            r_my_new <= r_quo;
        end
        if (i_cmd.commit) begin
            r_o_step_x <= n_sx;
            r_o_step_y <= n_sy;
            r_o_dir_x  <= n_dir_x;
            r_o_dir_y  <= n_dir_y;
            r_o_busy   <= n_moving;
            r_o_now_x  <= FW'($signed(n_pos_x));
            r_o_now_y  <= FW'($signed(n_pos_y));
        end
    end

    always_comb begin
        o_sts.moving    = r_moving;
        o_sts.gcd_done  = gcd_done;
        o_sts.null_move = (r_cx == '0) && (r_cy == '0);
        o_sts.div_done  = (r_dcnt == '0);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_step_x    = r_o_step_x;
    assign o_step_y    = r_o_step_y;
    assign o_dir_x     = r_o_dir_x;
    assign o_dir_y     = r_o_dir_y;
    assign o_busy_res  = r_o_busy;
    assign o_now_x     = r_o_now_x;
    assign o_now_y     = r_o_now_y;

endmodule
`default_nettype wire
